// ----- design/rpfa_pkg.sv -----
// rpfa_pkg: shared types and constants for the page-frame allocator
// request, status and configuration codes plus fixed field widths
// no dependencies
package rpfa_pkg;

    // fixed field widths
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 12;
    localparam int COUNT_W  = 8;
    localparam int FREE_W   = 13;
    localparam int FIRST_W  = 12;
    localparam int LIMIT_W  = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    typedef logic [REQ_W-1:0]     t_req;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // request codes
    localparam t_req REQ_ALLOC   = 2'd0;
    localparam t_req REQ_RELEASE = 2'd1;
    localparam t_req REQ_SHARE   = 2'd2;

    // status codes
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_NOMEM    = 3'd1;
    localparam t_status ST_RANGE    = 3'd2;
    localparam t_status ST_NOTALLOC = 3'd3;
    localparam t_status ST_SAT      = 3'd4;

    // configuration register indexes
    localparam t_cfg_idx CFG_FIRST_FRAME = 1'd0;
    localparam t_cfg_idx CFG_FRAME_LIMIT = 1'd1;

    // reset values and count ceiling
    localparam logic [FIRST_W-1:0] FIRST_RESET = 12'd1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;
    localparam logic [COUNT_W-1:0] REF_MAX     = 8'd255;

endpackage

// ----- design/refcounted_page_frame_allocator.sv -----
// refcounted_page_frame_allocator: first-fit page-frame allocator with 8-bit reference counts
// holds the count memory, the in-use bitmap memory and the sequencer
// depends on rpfa_pkg
//
// One request is taken at a time and answered with exactly one result. Reference counts live
// in a NUM_FRAMES x 8 memory; a second memory holds one in-use bit per frame, 32 frames per
// word (fewer for very small NUM_FRAMES), and a count is only trusted where its bit is set.
// A release or share goes through read, then modify and write back, then result, and the next
// request can be taken once the result is loaded into the output register, which waits while a
// result still held there is stalled. An allocate reads bitmap words from the first word of the
// range, one word per cycle, until the first free frame turns up: at most the words that the
// range touches, 128 at the default size. A request refused at once for its index or type goes
// straight to its result. After reset a clearing pass writes the whole bitmap, one word a
// cycle, during which no request is taken. After a configuration write the in-use total is
// recounted over the new range before the next request, one bitmap word a cycle over the
// words that the range touches. The next request may be taken while a result still waits at
// the output.
module refcounted_page_frame_allocator
    import rpfa_pkg::*;
#(
    parameter int NUM_FRAMES = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_req                  i_req_type,
    input  logic [INDEX_W-1:0]    i_frame_index,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_status               o_status,
    output logic [INDEX_W-1:0]    o_result_frame,
    output logic [COUNT_W-1:0]    o_ref_count,
    output logic [FREE_W-1:0]     o_free_frames,
    // configuration port
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // geometry
    localparam int FW = $clog2(NUM_FRAMES);
    localparam int W  = (NUM_FRAMES >= 64) ? 32 : NUM_FRAMES / 2;
    localparam int OW = $clog2(W);
    localparam int NW = NUM_FRAMES / W;
    localparam int AW = FW - OW;
    localparam int CW = (FW + 1 > LIMIT_W) ? FW + 1 : LIMIT_W;

    // sequencer codes
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_COUNT = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    // memories and their read registers
    logic [W-1:0]       r_map_mem [NW];
    logic [COUNT_W-1:0] r_ref_mem [NUM_FRAMES];
    logic [W-1:0]       r_map_q;
    logic [COUNT_W-1:0] r_ref_q;

    // control and item registers
    logic [2:0]         r_state, n_state;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic [CW-1:0]      r_used, n_used;
    logic               r_dirty, n_dirty;
    logic [FW-1:0]      r_idx, n_idx;
    t_req               r_req, n_req;
    t_status            r_status, n_status;
    logic [INDEX_W-1:0] r_frame, n_frame;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [FIRST_W-1:0] r_first;
    logic [LIMIT_W-1:0] r_limit;

    // output registers
    logic               r_ovalid;
    t_status            r_ostatus;
    logic [INDEX_W-1:0] r_oframe;
    logic [COUNT_W-1:0] r_ocount;
    logic [FREE_W-1:0]  r_ofree;

    // memory port controls
    logic               map_we;
    logic [AW-1:0]      map_waddr, map_raddr;
    logic [W-1:0]       map_wdata;
    logic               ref_we;
    logic [FW-1:0]      ref_waddr, ref_raddr;
    logic [COUNT_W-1:0] ref_wdata;
    logic               load_out;

    // range arithmetic
    logic [CW-1:0] first_ext, limit_ext, lim, last, span, free_diff, idx_ext;
    logic          empty, in_rng;
    logic [AW-1:0] first_word, last_word;
    logic [OW-1:0] first_off, last_off;

    assign first_ext  = CW'(r_first);
    assign limit_ext  = CW'(r_limit);
    assign lim        = (limit_ext > CW'(NUM_FRAMES)) ? CW'(NUM_FRAMES) : limit_ext;
    assign empty      = first_ext >= lim;
    assign last       = lim - CW'(1);
    assign span       = empty ? '0 : (lim - first_ext);
    assign free_diff  = span - r_used;
    assign first_word = first_ext[FW-1:OW];
    assign first_off  = first_ext[OW-1:0];
    assign last_word  = last[FW-1:OW];
    assign last_off   = last[OW-1:0];
    assign idx_ext    = CW'(i_frame_index);
    assign in_rng     = (idx_ext >= first_ext) && (idx_ext < lim);

    // window of the current bitmap word that lies inside the managed range
    logic [W-1:0] lo_mask, hi_mask, used_vec, free_vec, lowest;
    logic [OW-1:0] enc;
    logic          found;
    logic [CW-1:0] found_ext;

    assign lo_mask  = (r_ptr == first_word) ? ({W{1'b1}} << first_off) : {W{1'b1}};
    assign hi_mask  = (r_ptr == last_word) ? ({W{1'b1}} >> (OW'(W - 1) - last_off))
                                           : {W{1'b1}};
    assign used_vec = r_map_q & lo_mask & hi_mask;
    assign free_vec = ~r_map_q & lo_mask & hi_mask;
    assign lowest   = free_vec & (~free_vec + W'(1));
    assign found    = |free_vec;

    // encode the isolated lowest free bit
    always_comb begin
        enc = '0;
        for (int j = 0; j < W; j++) begin
            if (lowest[j]) begin
                enc = enc | OW'(j);
            end
        end
    end

    assign found_ext = CW'({r_ptr, enc});

    // addressed frame during a release or share
    logic               map_bit;
    logic [COUNT_W-1:0] cur_cnt, dec_cnt, inc_cnt;

    assign map_bit = r_map_q[r_idx[OW-1:0]];
    assign cur_cnt = map_bit ? r_ref_q : '0;
    assign dec_cnt = cur_cnt - COUNT_W'(1);
    assign inc_cnt = cur_cnt + COUNT_W'(1);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_used    = r_used;
        n_dirty   = r_dirty | i_cfg_we;
        n_idx     = r_idx;
        n_req     = r_req;
        n_status  = r_status;
        n_frame   = r_frame;
        n_count   = r_count;
        map_we    = 1'b0;
        map_waddr = r_ptr;
        map_wdata = r_map_q | lowest;
        map_raddr = r_ptr + AW'(1);
        ref_we    = 1'b0;
        ref_waddr = r_idx;
        ref_wdata = COUNT_W'(1);
        ref_raddr = idx_ext[FW-1:0];
        load_out  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_wdata = '0;
                n_ptr     = r_ptr + AW'(1);
                if (r_ptr == AW'(NW - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (r_dirty) begin
                    // recount the in-use total over a new range
                    if (!i_cfg_we) begin
                        if (empty) begin
                            n_used  = '0;
                            n_dirty = 1'b0;
                        end else begin
                            n_state   = S_COUNT;
                            n_ptr     = first_word;
                            n_used    = '0;
                            map_raddr = first_word;
                        end
                    end
                end else if (i_valid) begin
                    // request transfer
                    n_req   = i_req_type;
                    n_idx   = idx_ext[FW-1:0];
                    n_frame = i_frame_index;
                    n_count = '0;
                    case (i_req_type)
                        REQ_ALLOC: begin
                            n_frame = '0;
                            if (empty) begin
                                n_status = ST_NOMEM;
                                n_state  = S_EMIT;
                            end else begin
                                n_ptr     = first_word;
                                map_raddr = first_word;
                                n_state   = S_SCAN;
                            end
                        end
                        REQ_RELEASE, REQ_SHARE: begin
                            if (in_rng) begin
                                map_raddr = idx_ext[FW-1:OW];
                                n_state   = S_UPD;
                            end else begin
                                n_status = ST_RANGE;
                                n_state  = S_EMIT;
                            end
                        end
                        default: begin
                            n_status = ST_RANGE;
                            n_state  = S_EMIT;
                        end
                    endcase
                end
            end
            S_COUNT: begin
                if (i_cfg_we) begin
                    n_state = S_IDLE;
                end else begin
                    n_used = r_used + CW'($countones(used_vec));
                    if (r_ptr == last_word) begin
                        n_dirty = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_ptr = r_ptr + AW'(1);
                    end
                end
            end
            S_SCAN: begin
                if (found) begin
                    map_we    = 1'b1;
                    ref_we    = 1'b1;
                    ref_waddr = {r_ptr, enc};
                    n_used    = r_used + CW'(1);
                    n_status  = ST_OK;
                    n_frame   = found_ext[INDEX_W-1:0];
                    n_count   = COUNT_W'(1);
                    n_state   = S_EMIT;
                end else if (r_ptr == last_word) begin
                    n_status = ST_NOMEM;
                    n_state  = S_EMIT;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_UPD: begin
                map_waddr = r_idx[FW-1:OW];
                map_wdata = r_map_q & ~(W'(1) << r_idx[OW-1:0]);
                n_state   = S_EMIT;
                if (cur_cnt == '0) begin
                    n_status = ST_NOTALLOC;
                end else if (r_req == REQ_RELEASE) begin
                    ref_we    = 1'b1;
                    ref_wdata = dec_cnt;
                    n_status  = ST_OK;
                    n_count   = dec_cnt;
                    if (dec_cnt == '0) begin
                        map_we = 1'b1;
                        n_used = r_used - CW'(1);
                    end
                end else if (cur_cnt == REF_MAX) begin
                    n_status = ST_SAT;
                    n_count  = REF_MAX;
                end else begin
                    ref_we    = 1'b1;
                    ref_wdata = inc_cnt;
                    n_status  = ST_OK;
                    n_count   = inc_cnt;
                end
            end
            S_EMIT: begin
                if (!r_ovalid || !i_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr   <= '0;
            r_used  <= '0;
            r_dirty <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_used  <= n_used;
            r_dirty <= n_dirty;
        end
    end

    // item registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_req    <= n_req;
        r_status <= n_status;
        r_frame  <= n_frame;
        r_count  <= n_count;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= FIRST_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIRST_FRAME: r_first <= i_cfg_data[FIRST_W-1:0];
                CFG_FRAME_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // bitmap memory
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_waddr] <= map_wdata;
        end
        r_map_q <= r_map_mem[map_raddr];
    end

    // count memory
    always_ff @(posedge i_clk) begin
        if (ref_we) begin
            r_ref_mem[ref_waddr] <= ref_wdata;
        end
        r_ref_q <= r_ref_mem[ref_raddr];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_ostatus <= r_status;
            r_oframe  <= r_frame;
            r_ocount  <= r_count;
            r_ofree   <= free_diff[FREE_W-1:0];
        end
    end

    assign o_stall        = !((r_state == S_IDLE) && !r_dirty);
    assign o_valid        = r_ovalid;
    assign o_status       = r_ostatus;
    assign o_result_frame = r_oframe;
    assign o_ref_count    = r_ocount;
    assign o_free_frames  = r_ofree;

    // in-use total stays within the range once recounted
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_dirty) |-> (r_used <= span))
        else $error("in-use total exceeds managed range");

    // every request transfer leaves the idle state
    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state != S_IDLE))
        else $error("request transfer did not start work");

    // a new result appears only out of the result state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid)) |-> ($past(r_state) == S_EMIT))
        else $error("result loaded outside the result state");

endmodule
